// ===== sv/tvs_pkg.sv =====
// Shared types, codes and constants of the tone/volume serial command writer.
package tvs_pkg;

  // Input select saturates at this channel number
  localparam int unsigned MAX_CHANNEL = 3;
  localparam int unsigned CH_W        = $clog2(MAX_CHANNEL + 1);
  localparam int unsigned CH_LSB      = 10;

  // Word layout
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned BIT_IDX_W = 4;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned VOL_W    = 8;
  localparam int unsigned MAG_W    = 4;
  localparam int unsigned SET_W    = 9;
  localparam int unsigned CMD_W    = 3;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_ADDRESS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_TICKS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HIGH_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_LOW_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS        = 3'd4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INPUT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TREBLE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BASS     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_VOL_BOTH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_VOL_B    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_VOL_A    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_MUTE     = 3'd6;

  // Chip register numbers, placed in bits 7..4
  localparam logic [3:0] REG_VOL_A  = 4'd0;
  localparam logic [3:0] REG_VOL_B  = 4'd1;
  localparam logic [3:0] REG_INPUT  = 4'd2;
  localparam logic [3:0] REG_TREBLE = 4'd3;
  localparam logic [3:0] REG_BASS   = 4'd4;

  localparam logic [VOL_W-1:0] MUTE_CODE = 8'hff;
  localparam logic [MAG_W-1:0] MAG_MAX   = 4'hf;

  // Command queue depth (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified command: the words to send
  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic              two_words;
  } tvs_cmd_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic not_empty;
  } tvs_qstat_t;

endpackage

// ===== sv/tvs_front.sv =====
// Front end: accepts commands, holds the chip address and builds the words.
module tvs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tvs_pkg::CMD_W-1:0]     cmd,
  input  logic signed [tvs_pkg::SET_W-1:0] setting,
  input  tvs_pkg::tvs_qstat_t           qstat,
  output logic                          push,
  output tvs_pkg::tvs_cmd_t             push_cmd
);
  import tvs_pkg::*;

  logic [ADDR_W-1:0] chip_addr_r, chip_addr_nxt;
  logic [SET_W-1:0]  abs_set;
  logic [MAG_W-1:0]  mag;
  logic [CH_W-1:0]   chan;
  logic [VOL_W-1:0]  vol;
  logic              cmd_ok;

  // Chip address is the only register that shapes a word; tick counts only
  // describe link timing and are taken without effect.
  assign cfg_ready = 1'b1;

  always_comb begin
    chip_addr_nxt = chip_addr_r;
    if (cfg_valid && cfg_index == CFG_CHIP_ADDRESS) begin
      chip_addr_nxt = cfg_data[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_addr_r <= '0;
    end else begin
      chip_addr_r <= chip_addr_nxt;
    end
  end

  // Saturate the channel to 0..MAX_CHANNEL
  always_comb begin
    if (setting[SET_W-1]) begin
      chan = '0;
    end else if (setting > $signed(SET_W'(MAX_CHANNEL))) begin
      chan = CH_W'(MAX_CHANNEL);
    end else begin
      chan = setting[CH_W-1:0];
    end
  end

  // Tone magnitude, saturated to four bits
  assign abs_set = setting[SET_W-1] ? (~setting + 1'b1) : setting;
  assign mag     = (abs_set > SET_W'(MAG_MAX)) ? MAG_MAX : abs_set[MAG_W-1:0];
  assign vol     = (cmd == CMD_MUTE) ? MUTE_CODE : setting[VOL_W-1:0];

  // Classify and build the word pair
  always_comb begin
    cmd_ok             = 1'b1;
    push_cmd.word0     = '0;
    push_cmd.word1     = '0;
    push_cmd.two_words = 1'b0;
    unique case (cmd) inside
      CMD_INPUT: begin
        push_cmd.word0 = (WORD_W'(chan) << CH_LSB) | {8'h00, REG_INPUT, chip_addr_r};
      end
      CMD_TREBLE: begin
        push_cmd.word0 = {~setting[SET_W-1], mag, 1'b1, 2'b00, REG_TREBLE, chip_addr_r};
      end
      CMD_BASS: begin
        push_cmd.word0 = {~setting[SET_W-1], mag, 1'b0, 2'b00, REG_BASS, chip_addr_r};
      end
      CMD_VOL_BOTH, CMD_MUTE: begin
        push_cmd.word0     = {vol, REG_VOL_A, chip_addr_r};
        push_cmd.word1     = {vol, REG_VOL_B, chip_addr_r};
        push_cmd.two_words = 1'b1;
      end
      CMD_VOL_B: begin
        push_cmd.word0 = {vol, REG_VOL_B, chip_addr_r};
      end
      CMD_VOL_A: begin
        push_cmd.word0 = {vol, REG_VOL_A, chip_addr_r};
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  // Take a transfer whenever the queue has room; drop undefined commands
  assign in_tready = !qstat.full;
  assign push      = in_tvalid && in_tready && cmd_ok;

endmodule

// ===== sv/tvs_queue.sv =====
// Short command queue between the front end and the serializer.
module tvs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tvs_pkg::tvs_cmd_t push_cmd,
  input  logic              pop,
  output tvs_pkg::tvs_cmd_t head_cmd,
  output tvs_pkg::tvs_qstat_t qstat
);
  import tvs_pkg::*;

  tvs_cmd_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign qstat.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.not_empty = (count_r != '0);
  assign head_cmd        = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/tvs_back.sv =====
// Back end: shifts out queued words one bit cell per transfer, MSB first.
module tvs_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tvs_pkg::tvs_qstat_t             qstat,
  input  tvs_pkg::tvs_cmd_t               head_cmd,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tvs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import tvs_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [WORD_W-1:0]    word0_r, word0_nxt;
  logic [WORD_W-1:0]    word1_r, word1_nxt;
  logic                 two_r, two_nxt;
  logic                 wsel_r, wsel_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic                 odata_r, odata_nxt;
  logic [BIT_IDX_W-1:0] opos_r, opos_nxt;
  logic                 oword_r, oword_nxt;
  logic                 oend_r, oend_nxt;
  logic                 olast_r, olast_nxt;
  logic                 adv;
  logic                 word_done;
  logic                 cmd_done;
  logic [WORD_W-1:0]    cur_word;

  assign adv       = !ovalid_r || out_tready;
  assign cur_word  = wsel_r ? word1_r : word0_r;
  assign word_done = (bit_r == '0);
  assign cmd_done  = word_done && (wsel_r || !two_r);
  // Load the next command in the cycle the current one sends its last cell
  assign pop       = adv && qstat.not_empty && (!busy_r || cmd_done);

  always_comb begin
    busy_nxt   = busy_r;
    word0_nxt  = word0_r;
    word1_nxt  = word1_r;
    two_nxt    = two_r;
    wsel_nxt   = wsel_r;
    bit_nxt    = bit_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    opos_nxt   = opos_r;
    oword_nxt  = oword_r;
    oend_nxt   = oend_r;
    olast_nxt  = olast_r;
    if (adv) begin
      // Emit one bit cell into the output register
      ovalid_nxt = busy_r;
      odata_nxt  = cur_word[bit_r];
      opos_nxt   = bit_r;
      oword_nxt  = wsel_r;
      oend_nxt   = word_done;
      olast_nxt  = cmd_done;
      if (busy_r) begin
        if (!word_done) begin
          bit_nxt = bit_r - 1'b1;
        end else if (!cmd_done) begin
          wsel_nxt = 1'b1;
          bit_nxt  = '1;
        end else begin
          busy_nxt = 1'b0;
        end
      end
      if (pop) begin
        busy_nxt  = 1'b1;
        word0_nxt = head_cmd.word0;
        word1_nxt = head_cmd.word1;
        two_nxt   = head_cmd.two_words;
        wsel_nxt  = 1'b0;
        bit_nxt   = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word0_r <= word0_nxt;
    word1_r <= word1_nxt;
    two_r   <= two_nxt;
    wsel_r  <= wsel_nxt;
    bit_r   <= bit_nxt;
    odata_r <= odata_nxt;
    opos_r  <= opos_nxt;
    oword_r <= oword_nxt;
    oend_r  <= oend_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, oend_r, oword_r, opos_r, odata_r};
  assign out_tlast  = olast_r;

endmodule

// ===== sv/tone_volume_serial_command_writer.sv =====
// Top level of the tone/volume serial command writer.
// Each accepted command is turned into one or two 16-bit register words for the
// audio chip and sent out as one transfer per serial bit cell, MSB first: input
// select, treble, bass and single volume commands give 16 transfers, volume
// both and mute give 32 (register A, then B), and command 7 gives none. The
// serializer sends one bit cell per clock while the receiver is ready, and
// consecutive commands follow back to back. A two-entry queue sits between the
// command front end and the serializer, so while output is stalled up to two
// commands wait there besides the one the serializer holds. Only the chip
// address register affects the words; the tick count registers are accepted
// and change no result.
module tone_volume_serial_command_writer (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tvs_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Command stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tvs_pkg::IN_TDATA_W-1:0]  in_tdata,   // [2:0] command, [11:3] setting
  // Bit cell stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tvs_pkg::OUT_TDATA_W-1:0] out_tdata,  // [0] data_bit, [4:1] bit_position,
                                                      // [5] word_number, [6] word_end
  output logic                            out_tlast   // last
);
  import tvs_pkg::*;

  tvs_qstat_t qstat;
  tvs_cmd_t   push_cmd;
  tvs_cmd_t   head_cmd;
  logic       push;
  logic       pop;

  tvs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (in_tdata[CMD_W-1:0]),
    .setting   (in_tdata[CMD_W+SET_W-1:CMD_W]),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tvs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .qstat    (qstat)
  );

  tvs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/tvs_checker.sv =====
// Port-level checks of the serial command writer, bound to the top level.
module tvs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Hold a stalled transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transfer changed");

  // Command end falls on the end of a word
  a_last_on_word_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[6])
    else $error("last set off a word end");

  // Word end marks bit 0 and only bit 0
  a_word_end_bit0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6] == (out_tdata[4:1] == 4'd0)))
    else $error("word end does not match bit position");

  // Bits of a word count down by one across transfers
  a_bit_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tdata[6] ##1 out_tvalid
      |-> out_tdata[4:1] == $past(out_tdata[4:1]) - 4'd1)
    else $error("bit position did not step down");

  // Output is empty after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind tone_volume_serial_command_writer tvs_checker u_tvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== test/tone_volume_serial_command_writer_tb.sv =====
// Self-checking testbench for the tone/volume serial command writer.
module tone_volume_serial_command_writer_tb;
  import tvs_pkg::*;

  // Command 7 has no meaning and must produce no bit cells
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;
  localparam logic [WORD_W-1:0] SIGN_BIT      = 16'h8000;
  // Quiet cycles after the last bit cell before touching registers or ending
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RESET_CYCLES = 11;

  // One expected bit cell, one field per output
  typedef struct packed {
    logic                 data_bit;
    logic [BIT_IDX_W-1:0] bit_pos;
    logic                 word_num;
    logic                 word_end;
    logic                 last;
  } bit_cell_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [2:0] command, [11:3] setting

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [0] data_bit, [4:1] bit_position,
                                            // [5] word_number, [6] word_end
  logic                   out_tlast;        // last

  bit_cell_t   pending_cells[$];
  logic [ADDR_W-1:0] model_chip_addr = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned commands_sent = 0;
  int unsigned cells_checked = 0;
  int unsigned reg_writes = 0;

  tone_volume_serial_command_writer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Receiver back-pressure, rolled every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Queue the bit cells of one 16-bit word, MSB first
  function automatic void queue_word(input logic [WORD_W-1:0] word, input logic word_num,
                                     input logic final_word);
    bit_cell_t entry;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      entry.data_bit = word[b];
      entry.bit_pos  = BIT_IDX_W'(b);
      entry.word_num = word_num;
      entry.word_end = (b == 0);
      entry.last     = (b == 0) && final_word;
      pending_cells.push_back(entry);
    end
  endfunction

  // Build the register words of one command and queue their bit cells
  function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                          input logic [SET_W-1:0] setting);
    int                level;
    int                chan;
    int                mag;
    logic [VOL_W-1:0]  vol;
    logic [WORD_W-1:0] tone;
    level = $signed(setting);
    vol   = setting[VOL_W-1:0];
    mag   = (level < 0) ? -level : level;
    if (mag > MAG_MAX) mag = MAG_MAX;
    tone  = {1'b0, 4'(mag), 3'b000, 4'h0, model_chip_addr};
    if (level >= 0) tone = tone | SIGN_BIT;
    case (cmd) inside
      CMD_INPUT: begin
        chan = level;
        if (chan < 0) chan = 0;
        if (chan > int'(MAX_CHANNEL)) chan = MAX_CHANNEL;
        queue_word(WORD_W'(chan << CH_LSB) | {8'h00, REG_INPUT, model_chip_addr}, 1'b0, 1'b1);
      end
      CMD_TREBLE: begin
        queue_word(tone | {5'b0, 1'b1, 2'b00, REG_TREBLE, 4'h0}, 1'b0, 1'b1);
      end
      CMD_BASS: begin
        queue_word(tone | {8'h00, REG_BASS, 4'h0}, 1'b0, 1'b1);
      end
      CMD_VOL_BOTH, CMD_MUTE: begin
        if (cmd == CMD_MUTE) vol = MUTE_CODE;
        queue_word({vol, REG_VOL_A, model_chip_addr}, 1'b0, 1'b0);
        queue_word({vol, REG_VOL_B, model_chip_addr}, 1'b1, 1'b1);
      end
      CMD_VOL_B: begin
        queue_word({vol, REG_VOL_B, model_chip_addr}, 1'b0, 1'b1);
      end
      CMD_VOL_A: begin
        queue_word({vol, REG_VOL_A, model_chip_addr}, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Track register writes, predict on each command transfer, check each bit cell
  always @(posedge clk) begin
    bit_cell_t want;
    bit_cell_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready && cfg_index == CFG_CHIP_ADDRESS)
        model_chip_addr = cfg_data[ADDR_W-1:0];
      if (in_tvalid && in_tready)
        predict_command(in_tdata[CMD_W-1:0], in_tdata[CMD_W+SET_W-1:CMD_W]);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[4:1], out_tdata[5], out_tdata[6], out_tlast};
        cells_checked++;
        if (pending_cells.size() == 0) begin
          $display("%0t: unexpected bit cell, expected none, actual %b", $time, got);
          error_count++;
        end else begin
          want = pending_cells.pop_front();
          if (got.data_bit !== want.data_bit) begin
            $display("%0t: data_bit expected %b actual %b", $time, want.data_bit, got.data_bit);
            error_count++;
          end
          if (got.bit_pos !== want.bit_pos) begin
            $display("%0t: bit_position expected %0d actual %0d", $time, want.bit_pos,
                     got.bit_pos);
            error_count++;
          end
          if (got.word_num !== want.word_num) begin
            $display("%0t: word_number expected %b actual %b", $time, want.word_num,
                     got.word_num);
            error_count++;
          end
          if (got.word_end !== want.word_end) begin
            $display("%0t: word_end expected %b actual %b", $time, want.word_end,
                     got.word_end);
            error_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            error_count++;
          end
        end
      end
    end
  end

  // Offer one command, with random idle cycles ahead of it, and hold until the transfer
  task automatic send_command(input logic [CMD_W-1:0] cmd, input int setting);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, SET_W'(setting), cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    commands_sent++;
  endtask

  // Drop the command stream and wait until every bit cell is out and the block is quiet
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic configure(input logic [ADDR_W-1:0] addr, input logic [15:0] lead,
                           input logic [15:0] high, input logic [15:0] low,
                           input logic [15:0] gap);
    write_register(CFG_CHIP_ADDRESS, CFG_DATA_W'(addr));
    write_register(CFG_LEAD_TICKS, lead);
    write_register(CFG_CLOCK_HIGH_TICKS, high);
    write_register(CFG_CLOCK_LOW_TICKS, low);
    write_register(CFG_GAP_TICKS, gap);
  endtask

  // Mostly uniform over the legal range, sometimes a saturation or wrap boundary
  function automatic int rand_setting();
    int edges[11] = '{-255, -16, -15, -1, 0, 1, 3, 4, 15, 16, 255};
    if ($urandom_range(3) == 0) return edges[$urandom_range(10)];
    return int'($urandom_range(510)) - 255;
  endfunction

  task automatic test_reset_defaults;
    send_command(CMD_VOL_A, 8'h5a);
    send_command(CMD_INPUT, 2);
  endtask

  task automatic test_config_registers;
    configure(4'hf, 16'd1, 16'd1, 16'd1, 16'd1);
    // Indexes past the last register must be ignored
    write_register(3'd5, 16'hffff);
    write_register(3'd6, 16'h0000);
    write_register(3'd7, 16'h0005);
  endtask

  task automatic test_input_select;
    send_command(CMD_INPUT, -255);
    send_command(CMD_INPUT, -1);
    send_command(CMD_INPUT, 0);
    send_command(CMD_INPUT, MAX_CHANNEL);
    send_command(CMD_INPUT, MAX_CHANNEL + 1);
    send_command(CMD_INPUT, 255);
  endtask

  task automatic test_tone;
    write_register(CFG_CHIP_ADDRESS, 16'h0000);
    send_command(CMD_TREBLE, -255);
    send_command(CMD_TREBLE, -15);
    send_command(CMD_TREBLE, 0);
    send_command(CMD_TREBLE, 15);
    send_command(CMD_TREBLE, 16);
    send_command(CMD_BASS, -16);
    send_command(CMD_BASS, -1);
    send_command(CMD_BASS, 1);
    send_command(CMD_BASS, 255);
  endtask

  task automatic test_volume_and_mute;
    write_register(CFG_CHIP_ADDRESS, 16'h000a);
    send_command(CMD_VOL_BOTH, 255);
    send_command(CMD_VOL_A, 0);
    // Negative settings wrap to their low byte
    send_command(CMD_VOL_B, -1);
    send_command(CMD_VOL_A, -255);
    // Mute ignores the setting
    send_command(CMD_MUTE, -255);
    send_command(CMD_MUTE, 170);
  endtask

  task automatic test_undefined_command;
    send_command(CMD_UNDEFINED, 255);
    send_command(CMD_VOL_B, 1);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned      counted;
    logic [CMD_W-1:0] cmd;
    counted = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (counted < n_items) begin
      if ($urandom_range(99) < 6) begin
        cmd = CMD_UNDEFINED;
      end else begin
        cmd = CMD_W'($urandom_range(6));
        counted++;
      end
      send_command(cmd, rand_setting());
    end
    drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_config_registers();
    test_input_select();
    test_tone();
    test_volume_and_mute();
    test_undefined_command();

    configure(4'hf, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    test_random_traffic(44, 0, 0);
    configure(4'h0, 16'd1, 16'd1, 16'd1, 16'd1);
    test_random_traffic(44, 48, 0);
    configure(ADDR_W'($urandom_range(15)), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535)));
    test_random_traffic(44, 0, 48);
    configure(ADDR_W'($urandom_range(15)), 16'd20, 16'd40, 16'd20, 16'd50);
    test_random_traffic(45, 9, 9);

    if (pending_cells.size() != 0) begin
      $display("%0t: %0d bit cells never arrived", $time, pending_cells.size());
      error_count++;
    end
    $display("tb: %0d commands sent, %0d bit cells checked, %0d register writes",
             commands_sent, cells_checked, reg_writes);
    $display("tb: directed saturation and wrap cases, then four flow-control phases");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
